// ----- rtl/core/mi4_pkg.sv -----
// Shared types, constants and saturating arithmetic for the 4x4 matrix inverse.
package mi4_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ACC_WIDTH  = 64;
    localparam int MAT_DEPTH  = 16;
    localparam int SCR_DEPTH  = 32;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam int SCR_AW     = $clog2(SCR_DEPTH);

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam acc_t ONE_Q   = acc_t'(1) <<< FRAC_BITS;
    localparam acc_t WORD_HI = (acc_t'(1) <<< (WORD_WIDTH-1)) - acc_t'(1);
    localparam acc_t WORD_LO = -WORD_HI - acc_t'(1);

    typedef enum logic [1:0] {ACC_LOAD, ACC_SUB, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {PH_ROW, PH_DET, PH_OUT} phase_t;
    typedef enum logic [3:0] {
        S_IDLE, S_FETCH_A, S_FETCH_B, S_FETCH_C, S_MUL, S_MUL_WAIT,
        S_DIV, S_DIV_WAIT, S_EMIT, S_HOLD
    } state_t;

    // one micro-op of the cofactor / determinant / output sequence
    typedef struct packed {
        logic              x_mat;
        logic [SCR_AW-1:0] x_addr;
        logic              y_recip;
        logic [MAT_AW-1:0] y_addr;
        acc_op_t           op;
        logic              wr;
        logic [SCR_AW-1:0] wr_addr;
        logic              neg;
    } mop_t;

    function automatic acc_t sadd(acc_t a, acc_t b);
        acc_t s;
        s = a + b;
        if (a[ACC_WIDTH-1] == b[ACC_WIDTH-1] && s[ACC_WIDTH-1] != a[ACC_WIDTH-1])
            return a[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
        return s;
    endfunction

    function automatic acc_t ssub(acc_t a, acc_t b);
        acc_t d;
        d = a - b;
        if (a[ACC_WIDTH-1] != b[ACC_WIDTH-1] && d[ACC_WIDTH-1] != a[ACC_WIDTH-1])
            return a[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
        return d;
    endfunction

    function automatic acc_t sneg(acc_t a);
        return (a == ACC_MIN) ? ACC_MAX : -a;
    endfunction

    function automatic logic [ACC_WIDTH-1:0] magnitude(acc_t a);
        return a[ACC_WIDTH-1] ? (~a + 1'b1) : a;
    endfunction

endpackage

// ----- rtl/core/mi4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/mi4_mulq.sv -----
// Multi-cycle fixed-point multiply: 32x32 partial products, rounding and saturation.
module mi4_mulq import mi4_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  acc_t a,
    input  acc_t b,
    output logic done,
    output acc_t product
);

    localparam logic [2*ACC_WIDTH-1:0] HALF = (2*ACC_WIDTH)'(1) << (FRAC_BITS-1);

    logic [ACC_WIDTH-1:0]   xm_reg, ym_reg, pp_reg;
    logic                   neg_reg;
    logic [1:0]             sh_reg;
    logic [2*ACC_WIDTH-1:0] acc_reg;
    logic [2:0]             cnt_reg;
    logic                   busy_reg, done_reg;
    acc_t                   product_reg;

    logic [31:0]            xa, ya;
    logic [ACC_WIDTH-1:0]   pp_w;
    logic [2*ACC_WIDTH-1:0] pp_shift, rounded;
    logic [ACC_WIDTH-1:0]   r;
    acc_t                   res;

    assign xa   = cnt_reg[1] ? xm_reg[63:32] : xm_reg[31:0];
    assign ya   = cnt_reg[0] ? ym_reg[63:32] : ym_reg[31:0];
    assign pp_w = xa * ya;

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shift = {64'b0, pp_reg};
            2'd1:    pp_shift = {32'b0, pp_reg, 32'b0};
            default: pp_shift = {pp_reg, 64'b0};
        endcase
        rounded = acc_reg + HALF;
        r       = rounded[ACC_WIDTH+FRAC_BITS-1:FRAC_BITS];
        if (|rounded[2*ACC_WIDTH-1:ACC_WIDTH+FRAC_BITS])
            res = neg_reg ? ACC_MIN : ACC_MAX;
        else if (neg_reg)
            res = r[ACC_WIDTH-1] ? ACC_MIN : -acc_t'(r);
        else
            res = r[ACC_WIDTH-1] ? ACC_MAX : acc_t'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xm_reg  <= magnitude(a);
            ym_reg  <= magnitude(b);
            neg_reg <= a[ACC_WIDTH-1] ^ b[ACC_WIDTH-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= 3'd3)
            begin
                pp_reg <= pp_w;
                sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
            if (cnt_reg == 3'd5)
            begin
                product_reg <= res;
            end
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg && $past(busy_reg))
        else $error("mulq done without a finished multiply");
`endif

endmodule

// ----- rtl/core/mi4_div.sv -----
// Restoring divider for the rounded reciprocal of the determinant magnitude.
module mi4_div import mi4_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ACC_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [ACC_WIDTH-1:0] quotient
);

    localparam logic [ACC_WIDTH-1:0] NUM_ONE = ACC_WIDTH'(1) << (2*FRAC_BITS);
    localparam int CW = $clog2(ACC_WIDTH);

    logic [ACC_WIDTH-1:0] num_reg, d_reg;
    logic [ACC_WIDTH:0]   rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;
    logic [ACC_WIDTH:0]   rem_s;
    logic                 fits;

    assign rem_s = {rem_reg[ACC_WIDTH-1:0], num_reg[ACC_WIDTH-1]};
    assign fits  = rem_s >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= NUM_ONE + (divisor >> 1);
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_s - {1'b0, d_reg}) : rem_s;
            num_reg <= {num_reg[ACC_WIDTH-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ----- rtl/core/matrix_inverse_4x4.sv -----
// Top level: 4x4 fixed-point matrix inverse by cofactors, adjugate and one reciprocal.
// Loads one element per cycle while idle; the element flagged by in_last starts the computation.
// The computation runs 100 product terms on the one shared multiplier, then a divide for
// the reciprocal and one product per result, both skipped for a zero determinant.
// Each result is held while out_stall is high; input stays stalled until the last is taken.
// Reset (rst_n, async, active low) clears mode, load index, sequencer and valids.
module matrix_inverse_4x4 import mi4_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [WORD_WIDTH-1:0] in_elem,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_WIDTH-1:0] out_elem,
    output logic                         out_singular,
    output logic                         out_saturated,
    output logic                         out_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data
);

    localparam logic [4:0] ROW_LAST  = 5'd23;
    localparam logic [4:0] DET_LAST  = 5'd3;
    localparam logic [4:0] OUT_LAST  = 5'd15;
    localparam logic [1:0] ROW_FINAL = 2'd3;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] row_reg, row_next;
    logic [4:0] step_reg, step_next;
    logic [MAT_AW-1:0] load_idx_reg, load_idx_next;
    logic mode_reg;
    logic out_valid_reg, out_valid_next;
    acc_t recip_reg, recip_next;
    logic singular_reg, singular_next;

    acc_t x_reg, x_next, y_reg, y_next, acc_reg, acc_next;
    logic det_neg_reg, det_neg_next;
    logic [ACC_WIDTH-1:0] det_mag_reg, det_mag_next;
    logic signed [WORD_WIDTH-1:0] out_elem_reg, out_elem_next;
    logic out_sat_reg, out_sat_next, out_last_reg, out_last_next;
    logic [MAT_AW-1:0] rd_idx_reg;

    logic in_accept;
    logic [MAT_AW-1:0] mat_raddr;
    logic [WORD_WIDTH-1:0] mat_rdata;
    logic [SCR_AW-1:0] scr_raddr;
    acc_t scr_rdata;
    logic scr_we;
    acc_t acc_val, wr_val, clip_val;
    acc_t mat_val;
    logic clip_sat;
    mop_t mop;

    logic mul_start, mul_done, div_start, div_done;
    acc_t mul_product;
    logic [ACC_WIDTH-1:0] div_q;

    // micro-op decode: rows of the adjugate, determinant, then output products
    function automatic mop_t decode(phase_t ph, logic [1:0] row, logic [4:0] step);
        mop_t o;
        logic [1:0] ca, cb, k, r0, r1, rr, j, t;
        logic nf;
        logic [2:0] vi;
        o  = '0;
        vi = '0; rr = '0; j = '0; t = '0; r0 = '0; r1 = '0;
        case (row)
            2'd0:    begin ca = 2'd2; cb = 2'd3; k = 2'd1; nf = 1'b0; end
            2'd1:    begin ca = 2'd2; cb = 2'd3; k = 2'd0; nf = 1'b1; end
            2'd2:    begin ca = 2'd1; cb = 2'd3; k = 2'd0; nf = 1'b0; end
            default: begin ca = 2'd1; cb = 2'd2; k = 2'd0; nf = 1'b1; end
        endcase
        case (ph)
            PH_ROW:
            begin
                if (step < 5'd12)
                begin
                    vi = step[3:1];
                    case (vi)
                        3'd0:    begin r0 = 2'd0; r1 = 2'd1; end
                        3'd1:    begin r0 = 2'd0; r1 = 2'd2; end
                        3'd2:    begin r0 = 2'd0; r1 = 2'd3; end
                        3'd3:    begin r0 = 2'd1; r1 = 2'd2; end
                        3'd4:    begin r0 = 2'd1; r1 = 2'd3; end
                        default: begin r0 = 2'd2; r1 = 2'd3; end
                    endcase
                    o.x_mat = 1'b1;
                    if (!step[0])
                    begin
                        o.x_addr = {1'b0, r0, ca};
                        o.y_addr = {r1, cb};
                        o.op     = ACC_LOAD;
                    end
                    else
                    begin
                        o.x_addr  = {1'b0, r1, ca};
                        o.y_addr  = {r0, cb};
                        o.op      = ACC_SUB;
                        o.wr      = 1'b1;
                        o.wr_addr = {2'b10, vi};
                    end
                end
                else
                begin
                    case (step)
                        5'd12:   begin vi = 3'd5; rr = 2'd1; j = 2'd0; t = 2'd0; end
                        5'd13:   begin vi = 3'd4; rr = 2'd2; j = 2'd0; t = 2'd1; end
                        5'd14:   begin vi = 3'd3; rr = 2'd3; j = 2'd0; t = 2'd2; end
                        5'd15:   begin vi = 3'd5; rr = 2'd0; j = 2'd1; t = 2'd0; end
                        5'd16:   begin vi = 3'd2; rr = 2'd2; j = 2'd1; t = 2'd1; end
                        5'd17:   begin vi = 3'd1; rr = 2'd3; j = 2'd1; t = 2'd2; end
                        5'd18:   begin vi = 3'd4; rr = 2'd0; j = 2'd2; t = 2'd0; end
                        5'd19:   begin vi = 3'd2; rr = 2'd1; j = 2'd2; t = 2'd1; end
                        5'd20:   begin vi = 3'd0; rr = 2'd3; j = 2'd2; t = 2'd2; end
                        5'd21:   begin vi = 3'd3; rr = 2'd0; j = 2'd3; t = 2'd0; end
                        5'd22:   begin vi = 3'd1; rr = 2'd1; j = 2'd3; t = 2'd1; end
                        default: begin vi = 3'd0; rr = 2'd2; j = 2'd3; t = 2'd2; end
                    endcase
                    o.x_addr = {2'b10, vi};
                    o.y_addr = {rr, k};
                    case (t)
                        2'd0:    o.op = ACC_LOAD;
                        2'd1:    o.op = ACC_SUB;
                        default: o.op = ACC_ADD;
                    endcase
                    o.wr      = (t == 2'd2);
                    o.wr_addr = {1'b0, row, j};
                    o.neg     = nf ^ j[0];
                end
            end
            PH_DET:
            begin
                o.x_addr = {3'b000, step[1:0]};
                o.y_addr = {step[1:0], 2'b00};
                o.op     = (step == 5'd0) ? ACC_LOAD : ACC_ADD;
            end
            default:
            begin
                o.x_addr  = {1'b0, step[3:0]};
                o.y_recip = 1'b1;
                o.op      = ACC_LOAD;
            end
        endcase
        return o;
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign mop       = decode(phase_reg, row_reg, step_reg);

    // element read back with the 3x3 mode mask applied
    always_comb
    begin
        mat_val = {{(ACC_WIDTH-WORD_WIDTH){mat_rdata[WORD_WIDTH-1]}}, mat_rdata};
        if (mode_reg && (rd_idx_reg[1:0] == 2'd3 || rd_idx_reg[3:2] == 2'd3))
            mat_val = (rd_idx_reg == MAT_AW'(MAT_DEPTH-1)) ? ONE_Q : '0;
    end

    always_comb
    begin
        case (mop.op)
            ACC_LOAD: acc_val = mul_product;
            ACC_SUB:  acc_val = ssub(acc_reg, mul_product);
            default:  acc_val = sadd(acc_reg, mul_product);
        endcase
        wr_val   = mop.neg ? sneg(acc_val) : acc_val;
        clip_sat = 1'b0;
        clip_val = mul_product;
        if (mul_product > WORD_HI)
        begin
            clip_val = WORD_HI;
            clip_sat = 1'b1;
        end
        else if (mul_product < WORD_LO)
        begin
            clip_val = WORD_LO;
            clip_sat = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        step_next      = step_reg;
        load_idx_next  = load_idx_reg;
        out_valid_next = out_valid_reg;
        recip_next     = recip_reg;
        singular_next  = singular_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        det_neg_next   = det_neg_reg;
        det_mag_next   = det_mag_reg;
        out_elem_next  = out_elem_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        mat_raddr      = mop.x_mat ? mop.x_addr[MAT_AW-1:0] : mop.y_addr;
        scr_raddr      = mop.x_addr;
        scr_we         = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_last)
                    begin
                        load_idx_next = '0;
                        phase_next    = PH_ROW;
                        row_next      = '0;
                        step_next     = '0;
                        state_next    = S_FETCH_A;
                    end
                    else
                    begin
                        load_idx_next = load_idx_reg + 1'b1;
                    end
                end
            end
            S_FETCH_A:
            begin
                state_next = S_FETCH_B;
            end
            S_FETCH_B:
            begin
                if (mop.x_mat)
                begin
                    x_next     = mat_val;
                    mat_raddr  = mop.y_addr;
                    state_next = S_FETCH_C;
                end
                else
                begin
                    x_next     = scr_rdata;
                    y_next     = mop.y_recip ? recip_reg : mat_val;
                    state_next = S_MUL;
                end
            end
            S_FETCH_C:
            begin
                y_next     = mat_val;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = acc_val;
                    case (phase_reg)
                        PH_ROW:
                        begin
                            scr_we     = mop.wr;
                            state_next = S_FETCH_A;
                            if (step_reg == ROW_LAST)
                            begin
                                step_next = '0;
                                if (row_reg == ROW_FINAL)
                                    phase_next = PH_DET;
                                else
                                    row_next = row_reg + 2'd1;
                            end
                            else
                            begin
                                step_next = step_reg + 5'd1;
                            end
                        end
                        PH_DET:
                        begin
                            if (step_reg == DET_LAST)
                            begin
                                step_next    = '0;
                                phase_next   = PH_OUT;
                                det_neg_next = acc_val[ACC_WIDTH-1];
                                det_mag_next = magnitude(acc_val);
                                if (acc_val == '0)
                                begin
                                    singular_next = 1'b1;
                                    recip_next    = '0;
                                    state_next    = S_EMIT;
                                end
                                else
                                begin
                                    singular_next = 1'b0;
                                    state_next    = S_DIV;
                                end
                            end
                            else
                            begin
                                step_next  = step_reg + 5'd1;
                                state_next = S_FETCH_A;
                            end
                        end
                        default:
                        begin
                            out_elem_next  = clip_val[WORD_WIDTH-1:0];
                            out_sat_next   = clip_sat;
                            out_last_next  = (step_reg == OUT_LAST);
                            out_valid_next = 1'b1;
                            state_next     = S_HOLD;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    recip_next = det_neg_reg ? -acc_t'(div_q) : acc_t'(div_q);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (singular_reg)
                begin
                    out_elem_next  = '0;
                    out_sat_next   = 1'b0;
                    out_last_next  = (step_reg == OUT_LAST);
                    out_valid_next = 1'b1;
                    state_next     = S_HOLD;
                end
                else
                begin
                    state_next = S_FETCH_A;
                end
            end
            S_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (step_reg == OUT_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_ROW;
            row_reg       <= '0;
            step_reg      <= '0;
            load_idx_reg  <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            recip_reg     <= '0;
            singular_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            step_reg      <= step_next;
            load_idx_reg  <= load_idx_next;
            out_valid_reg <= out_valid_next;
            recip_reg     <= recip_next;
            singular_reg  <= singular_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        det_neg_reg  <= det_neg_next;
        det_mag_reg  <= det_mag_next;
        out_elem_reg <= out_elem_next;
        out_sat_reg  <= out_sat_next;
        out_last_reg <= out_last_next;
        rd_idx_reg   <= mat_raddr;
    end

    mi4_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MAT_DEPTH)) u_src_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (load_idx_reg),
        .wdata (in_elem),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // cofactors at 0..15, sub-determinants of the current row at 16..21
    mi4_ram #(.WIDTH(ACC_WIDTH), .DEPTH(SCR_DEPTH)) u_scr_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (mop.wr_addr),
        .wdata (wr_val),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    mi4_mulq u_mulq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (x_reg),
        .b       (y_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    mi4_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (det_mag_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid     = out_valid_reg;
    assign out_elem      = out_elem_reg;
    assign out_singular  = singular_reg;
    assign out_saturated = out_sat_reg;
    assign out_last      = out_last_reg;

`ifndef ASSERT_OFF
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_singular) |-> (out_elem == '0 && !out_saturated))
        else $error("singular result carries data");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_last) |=> !in_stall)
        else $error("input not reopened after last result");

    a_mul_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MUL_WAIT)
        else $error("multiply finished outside its wait state");
`endif

endmodule

// ----- bench/matrix_inverse_4x4_test.sv -----
// Self-checking bench for matrix_inverse_4x4: directed and random matrices against a predictor.
module matrix_inverse_4x4_test import mi4_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 3000;
    localparam int DRAIN_WAIT = 200;
    localparam int N_DIRECTED = 19;

    typedef enum int {TYPED_NONE, TYPED_IDENTITY, TYPED_SINGULAR} typed_t;

    typedef struct {
        logic [WORD_WIDTH-1:0] elem;
        logic                  singular;
        logic                  saturated;
        logic                  last;
    } inv_elem_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [WORD_WIDTH-1:0] in_elem;
    logic                         in_last;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [WORD_WIDTH-1:0] out_elem;
    logic                         out_singular;
    logic                         out_saturated;
    logic                         out_last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_data;

    matrix_inverse_4x4 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_elem       (in_elem),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_elem      (out_elem),
        .out_singular  (out_singular),
        .out_saturated (out_saturated),
        .out_last      (out_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [WORD_WIDTH-1:0] src_mat [16];
    logic [3:0]            load_ptr;
    logic                  mode_3x3;

    inv_elem_t inverse_q [$];
    int        mismatches;
    int        elems_sent;
    int        matrices_done;
    int        singular_seen;
    int        saturated_seen;
    int        idle_cycles;
    bit        hold_req;
    bit        calm;

    logic [WORD_WIDTH-1:0] dir_elem [N_DIRECTED] = '{
        32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
        32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000
    };
    logic   dir_last [N_DIRECTED] = '{0,0,0,0, 0,0,0,0, 0,0,0,0, 0,0,0,1, 1,1,1};
    typed_t dir_kind [N_DIRECTED] = '{
        TYPED_NONE, TYPED_NONE, TYPED_NONE, TYPED_NONE,
        TYPED_NONE, TYPED_NONE, TYPED_NONE, TYPED_NONE,
        TYPED_NONE, TYPED_NONE, TYPED_NONE, TYPED_NONE,
        TYPED_NONE, TYPED_NONE, TYPED_NONE, TYPED_IDENTITY,
        TYPED_SINGULAR, TYPED_NONE, TYPED_NONE
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic acc_t clamp_add(acc_t a, acc_t b);
        logic signed [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        return acc_t'(s[ACC_WIDTH-1:0]);
    endfunction

    function automatic acc_t clamp_sub(acc_t a, acc_t b);
        logic signed [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} - {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        return acc_t'(s[ACC_WIDTH-1:0]);
    endfunction

    function automatic acc_t clamp_neg(acc_t a);
        return (a == ACC_MIN) ? ACC_MAX : -a;
    endfunction

    function automatic logic [63:0] abs_u(acc_t a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // exact product, round half away from zero, drop FRAC_BITS, saturate
    function automatic acc_t fx_mul(acc_t a, acc_t b);
        logic [127:0] p;
        logic [63:0]  r;
        bit           neg;
        neg = a[63] != b[63];
        p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
        p = p + (128'd1 << (FRAC_BITS - 1));
        if (p[127:64+FRAC_BITS] != 0)
            return neg ? ACC_MIN : ACC_MAX;
        r = p[63+FRAC_BITS:FRAC_BITS];
        if (neg)
            return r[63] ? ACC_MIN : -acc_t'(r);
        return r[63] ? ACC_MAX : acc_t'(r);
    endfunction

    // cofactor / adjugate inverse of the stored matrix
    task automatic compute_inverse(output inv_elem_t res [16]);
        acc_t        m [4][4];
        acc_t        cof [4][4];
        acc_t        sd [6];
        acc_t        det;
        acc_t        recip;
        acc_t        e;
        logic [63:0] mag;
        logic [63:0] q;
        int pa [6] = '{0, 0, 0, 1, 1, 2};
        int pb [6] = '{0, 0, 0, 1, 1, 2};
        int col_a [4] = '{2, 2, 1, 1};
        int col_b [4] = '{3, 3, 3, 2};
        int col_k [4] = '{1, 0, 0, 0};
        int neg1 [4] = '{0, 1, 0, 1};
        int va [4] = '{5, 5, 4, 3};
        int ra [4] = '{1, 0, 0, 0};
        int vb [4] = '{4, 2, 2, 1};
        int rb [4] = '{2, 2, 1, 1};
        int vc [4] = '{3, 1, 0, 0};
        int rc [4] = '{3, 3, 3, 2};
        pb = '{1, 2, 3, 2, 3, 3};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = acc_t'(signed'(src_mat[i*4+j]));
        if (mode_3x3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m[i][3] = 0;
                m[3][i] = 0;
            end
            m[3][3] = ONE_Q;
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int i = 0; i < 6; i++)
                sd[i] = clamp_sub(fx_mul(m[pa[i]][col_a[r]], m[pb[i]][col_b[r]]),
                                  fx_mul(m[pb[i]][col_a[r]], m[pa[i]][col_b[r]]));
            for (int c = 0; c < 4; c++)
            begin
                cof[r][c] = clamp_add(clamp_sub(fx_mul(sd[va[c]], m[ra[c]][col_k[r]]),
                                                fx_mul(sd[vb[c]], m[rb[c]][col_k[r]])),
                                      fx_mul(sd[vc[c]], m[rc[c]][col_k[r]]));
                if ((neg1[r] ^ (c & 1)) != 0)
                    cof[r][c] = clamp_neg(cof[r][c]);
            end
        end
        det = 0;
        for (int j = 0; j < 4; j++)
            det = clamp_add(det, fx_mul(cof[0][j], m[j][0]));
        if (det == 0)
            recip = 0;
        else
        begin
            mag = abs_u(det);
            q = ((64'd1 << (2*FRAC_BITS)) + (mag >> 1)) / mag;
            recip = det[63] ? -acc_t'(q) : acc_t'(q);
        end
        for (int i = 0; i < 16; i++)
        begin
            res[i].last = (i == 15);
            res[i].singular = (det == 0);
            res[i].saturated = 1'b0;
            res[i].elem = '0;
            if (det != 0)
            begin
                e = fx_mul(cof[i>>2][i&3], recip);
                if (e > WORD_HI)
                begin
                    e = WORD_HI;
                    res[i].saturated = 1'b1;
                end
                if (e < WORD_LO)
                begin
                    e = WORD_LO;
                    res[i].saturated = 1'b1;
                end
                res[i].elem = e[WORD_WIDTH-1:0];
            end
        end
    endtask

    // store the element; on last, queue the sixteen inverse elements
    task automatic load_element(logic [WORD_WIDTH-1:0] e, logic last, typed_t kind);
        inv_elem_t res [16];
        src_mat[load_ptr] = e;
        if (!last)
        begin
            load_ptr = load_ptr + 4'd1;
            return;
        end
        load_ptr = 0;
        compute_inverse(res);
        for (int i = 0; i < 16; i++)
        begin
            if (kind == TYPED_IDENTITY)
            begin
                res[i].elem = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
                res[i].singular = 1'b0;
                res[i].saturated = 1'b0;
            end
            else if (kind == TYPED_SINGULAR)
            begin
                res[i].elem = 32'h0;
                res[i].singular = 1'b1;
                res[i].saturated = 1'b0;
            end
            inverse_q.push_back(res[i]);
        end
    endtask

    task automatic send_element(logic [WORD_WIDTH-1:0] e, logic last, typed_t kind);
        int gap;
        in_valid <= 1'b1;
        in_elem <= e;
        in_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        load_element(e, last, kind);
        elems_sent++;
        if (calm)
            gap = 0;
        else if ($urandom_range(99) < 70)
            gap = 0;
        else if ($urandom_range(99) < 85)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(60, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_mode(logic v);
        in_valid <= 1'b0;
        wait (inverse_q.size() == 0);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_3x3 = v;
    endtask

    function automatic logic [WORD_WIDTH-1:0] pick_element(int kind, int idx);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            2: return (idx % 5 == 0) ? $urandom_range(32'h0100_0000, 32'h0001_0000)
                                     : ($urandom_range(255) - 128);
            3: return (idx / 4 == 2) ? 32'h0 : $urandom;
            4: return (idx % 5 == 0) ? 32'h7f00_0000 + $urandom_range(32'hff_ffff) : 32'h0;
            default: return ($urandom_range(3) == 0) ? 32'h7fff_ffff
                          : (($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h0);
        endcase
    endfunction

    // one random matrix transaction: mostly 16 elements, some early or long
    task automatic send_random_matrix();
        int kind;
        int len;
        int sel;
        kind = $urandom_range(5);
        sel = $urandom_range(99);
        if (sel < 80)
            len = 16;
        else if (sel < 92)
            len = $urandom_range(15, 1);
        else
            len = $urandom_range(24, 17);
        for (int i = 0; i < len; i++)
            send_element(pick_element(kind, i), i == len - 1, TYPED_NONE);
    endtask

    // receiver idling
    initial
    begin
        int  len;
        logic st;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                st = 1'b1;
                len = LONG_HOLD;
            end
            else if (calm || $urandom_range(99) < 60)
            begin
                st = 1'b0;
                len = $urandom_range(20, 1);
            end
            else
            begin
                st = 1'b1;
                len = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(4, 1);
            end
            out_stall <= st;
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: elem %h sing %b sat %b last %b",
                             out_elem, out_singular, out_saturated, out_last);
            end
            else
            begin
                inv_elem_t x;
                x = inverse_q.pop_front();
                if (out_elem !== x.elem || out_singular !== x.singular ||
                    out_saturated !== x.saturated || out_last !== x.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                                 x.elem, x.singular, x.saturated, x.last,
                                 out_elem, out_singular, out_saturated, out_last);
                end
                if (x.last)
                    matrices_done++;
                if (x.singular)
                    singular_seen++;
                if (x.saturated)
                    saturated_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_elem = '0;
        in_last = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        for (int i = 0; i < 16; i++)
            src_mat[i] = '0;
        load_ptr = 0;
        mode_3x3 = 1'b0;
        mismatches = 0;
        elems_sent = 0;
        matrices_done = 0;
        singular_seen = 0;
        saturated_seen = 0;
        idle_cycles = 0;
        hold_req = 0;
        calm = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        for (int i = 0; i < N_DIRECTED; i++)
            send_element(dir_elem[i], dir_last[i], dir_kind[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode(ph[0] ? 1'b0 : 1'b1);
            calm = (ph == 1);
            if (ph == 2)
                hold_req = 1;
            for (int b = 0; b < 7; b++)
            begin
                if (ph == 3 && b == 3)
                begin
                    in_valid <= 1'b0;
                    wait (inverse_q.size() == 0);
                end
                send_random_matrix();
            end
        end
        in_valid <= 1'b0;
        calm = 0;

        wait (inverse_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d elements, %0d inverse matrices in both modes", elems_sent,
                 matrices_done);
        $display("singular elements %0d, clipped elements %0d, mismatches %0d",
                 singular_seen, saturated_seen, mismatches);
        if (mismatches == 0 && inverse_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
